// ===== rtl/gbfs_pkg.sv =====
// Package for the grid breadth-first path finder.
// Holds the beat payload types, the controller state and direction enums and default sizes.
// No dependencies.
package gbfs_pkg;

  localparam int COLS_DEF = 16;
  localparam int ROWS_DEF = 12;
  localparam int CELL_W   = 8;
  localparam int EPOCH_W  = 4;

  typedef struct packed {
    logic [CELL_W-1:0] start_cell;
    logic [CELL_W-1:0] goal_cell;
  } gbfs_req_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_res;
    logic              last;
  } gbfs_res_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_DEQ,
    ST_CUR,
    ST_NB,
    ST_NB_END,
    ST_WALK_RD,
    ST_WALK_CHK
  } gbfs_state_e;

  typedef enum logic [1:0] {
    DIR_LEFT,
    DIR_UP,
    DIR_DOWN,
    DIR_RIGHT
  } gbfs_dir_e;

endpackage

// ===== rtl/grid_bfs_path_finder.sv =====
// Top level of the grid breadth-first path finder: controller, cell memory and queue memory.
// Depends on gbfs_pkg for the beat types, the state and direction enums and default sizes.
//
// Each request beat names a start and a goal cell on an open COLS by ROWS four-connected
// grid; the block answers with the shortest path as result beats, goal first, then the
// parents back toward the start (the start itself is not sent unless it is the goal), last
// set on the final beat. A request with a cell outside the grid is taken and yields no
// beats. The visited marks and parents share one single-port-read memory tagged with a
// 4-bit search number, and the queue sits in a second memory. Each dequeued cell takes a
// queue read, a goal compare and up to four neighbor reads, each write-back coming in the
// cycle after its read. The start index is split into row and column by repeated
// subtraction; each result beat takes a parent read and an output step. After reset, and
// after every fifteenth search, a pass clears all cells before a request is taken.
module grid_bfs_path_finder
  import gbfs_pkg::*;
#(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  gbfs_req_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output gbfs_res_t out_data_o
);

  localparam int NCELLS  = COLS * ROWS;
  localparam int MAX_RES = COLS + ROWS - 2;
  localparam int IDX_W   = $clog2(NCELLS);
  localparam int PTR_W   = $clog2(NCELLS + 1);
  localparam int COL_W   = $clog2(COLS);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int RC_W    = ROW_W + COL_W;
  localparam int ENT_W   = EPOCH_W + IDX_W;
  localparam int CNT_W   = $clog2(MAX_RES + 1);

  localparam logic [IDX_W-1:0]   COLS_I    = IDX_W'(COLS);
  localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(NCELLS - 1);
  localparam logic [ROW_W-1:0]   ROW_MAX   = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]   COL_MAX   = COL_W'(COLS - 1);
  localparam logic [CNT_W-1:0]   CNT_MAX   = CNT_W'(MAX_RES);
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};
  localparam logic [EPOCH_W-1:0] EPOCH_ONE = EPOCH_W'(1);

  gbfs_state_e        state_q, state_d;
  gbfs_dir_e          dir_q, dir_d;
  logic [IDX_W-1:0]   start_q, start_d;
  logic [IDX_W-1:0]   goal_q, goal_d;
  logic [IDX_W-1:0]   rem_q, rem_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [ROW_W-1:0]   cur_row_q, cur_row_d;
  logic [COL_W-1:0]   cur_col_q, cur_col_d;
  logic [IDX_W-1:0]   cur_idx_q, cur_idx_d;
  logic [PTR_W-1:0]   head_q, head_d;
  logic [PTR_W-1:0]   tail_q, tail_d;
  logic               pend_q, pend_d;
  logic [IDX_W-1:0]   prev_idx_q, prev_idx_d;
  logic [ROW_W-1:0]   prev_row_q, prev_row_d;
  logic [COL_W-1:0]   prev_col_q, prev_col_d;
  logic [IDX_W-1:0]   node_q, node_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic [IDX_W-1:0]   clr_q, clr_d;
  logic               out_valid_q, out_valid_d;
  gbfs_res_t          out_q, out_d;

  logic [ENT_W-1:0] vis_mem [NCELLS];
  logic             vis_re, vis_we;
  logic [IDX_W-1:0] vis_raddr, vis_waddr;
  logic [ENT_W-1:0] vis_wdata, vis_rdata_q;

  logic [RC_W-1:0]  q_mem [NCELLS];
  logic             q_re, q_we;
  logic [IDX_W-1:0] q_raddr, q_waddr;
  logic [RC_W-1:0]  q_wdata, q_rdata_q;

  logic             nb_ok;
  logic [IDX_W-1:0] nb_idx;
  logic [ROW_W-1:0] nb_row;
  logic [COL_W-1:0] nb_col;
  logic [ROW_W-1:0] deq_row;
  logic [COL_W-1:0] deq_col;
  logic [IDX_W-1:0] deq_idx;
  logic [IDX_W-1:0] par;
  logic             walk_last;

  always_ff @(posedge clk_i) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
    if (vis_re) begin
      vis_rdata_q <= vis_mem[vis_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    if (q_re) begin
      q_rdata_q <= q_mem[q_raddr];
    end
  end

  assign deq_row = q_rdata_q[RC_W-1:COL_W];
  assign deq_col = q_rdata_q[COL_W-1:0];
  assign deq_idx = IDX_W'(IDX_W'(deq_row) * COLS_I + IDX_W'(deq_col));
  assign par     = vis_rdata_q[IDX_W-1:0];
  assign walk_last = (start_q == goal_q) || (cnt_q >= CNT_MAX) ||
                     (int'(par) >= NCELLS) || (par == start_q);

  always_comb begin
    nb_ok  = 1'b0;
    nb_idx = cur_idx_q;
    nb_row = cur_row_q;
    nb_col = cur_col_q;
    case (dir_q)
      DIR_LEFT: begin
        nb_ok  = (cur_col_q != '0);
        nb_idx = cur_idx_q - IDX_W'(1);
        nb_col = cur_col_q - COL_W'(1);
      end
      DIR_UP: begin
        nb_ok  = (cur_row_q != '0);
        nb_idx = cur_idx_q - COLS_I;
        nb_row = cur_row_q - ROW_W'(1);
      end
      DIR_DOWN: begin
        nb_ok  = (cur_row_q != ROW_MAX);
        nb_idx = cur_idx_q + COLS_I;
        nb_row = cur_row_q + ROW_W'(1);
      end
      DIR_RIGHT: begin
        nb_ok  = (cur_col_q != COL_MAX);
        nb_idx = cur_idx_q + IDX_W'(1);
        nb_col = cur_col_q + COL_W'(1);
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    dir_d       = dir_q;
    start_d     = start_q;
    goal_d      = goal_q;
    rem_d       = rem_q;
    row_d       = row_q;
    cur_row_d   = cur_row_q;
    cur_col_d   = cur_col_q;
    cur_idx_d   = cur_idx_q;
    head_d      = head_q;
    tail_d      = tail_q;
    pend_d      = pend_q;
    prev_idx_d  = prev_idx_q;
    prev_row_d  = prev_row_q;
    prev_col_d  = prev_col_q;
    node_d      = node_q;
    cnt_d       = cnt_q;
    epoch_d     = epoch_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    vis_re      = 1'b0;
    vis_raddr   = node_q;
    vis_we      = 1'b0;
    vis_waddr   = prev_idx_q;
    vis_wdata   = {epoch_q, cur_idx_q};
    q_re        = 1'b0;
    q_raddr     = head_q[IDX_W-1:0];
    q_we        = 1'b0;
    q_waddr     = tail_q[IDX_W-1:0];
    q_wdata     = {prev_row_q, prev_col_q};

    if ((state_q == ST_NB || state_q == ST_NB_END) && pend_q &&
        (vis_rdata_q[ENT_W-1:IDX_W] != epoch_q)) begin
      vis_we = 1'b1;
      q_we   = 1'b1;
      tail_d = tail_q + PTR_W'(1);
    end

    case (state_q)
      ST_CLEAR: begin
        vis_we    = 1'b1;
        vis_waddr = clr_q;
        vis_wdata = '0;
        if (clr_q == LAST_IDX) begin
          epoch_d = EPOCH_ONE;
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + IDX_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid_i && int'(in_data_i.start_cell) < NCELLS &&
            int'(in_data_i.goal_cell) < NCELLS) begin
          start_d = IDX_W'(in_data_i.start_cell);
          goal_d  = IDX_W'(in_data_i.goal_cell);
          rem_d   = IDX_W'(in_data_i.start_cell);
          row_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_q >= COLS_I) begin
          rem_d = rem_q - COLS_I;
          row_d = row_q + ROW_W'(1);
        end else begin
          vis_we    = 1'b1;
          vis_waddr = start_q;
          vis_wdata = {epoch_q, start_q};
          q_we      = 1'b1;
          q_waddr   = '0;
          q_wdata   = {row_q, COL_W'(rem_q)};
          head_d    = '0;
          tail_d    = PTR_W'(1);
          state_d   = ST_DEQ;
        end
      end
      ST_DEQ: begin
        if (head_q == tail_q) begin
          node_d  = goal_q;
          cnt_d   = CNT_W'(1);
          state_d = ST_WALK_RD;
        end else begin
          q_re    = 1'b1;
          head_d  = head_q + PTR_W'(1);
          state_d = ST_CUR;
        end
      end
      ST_CUR: begin
        if (deq_idx == goal_q) begin
          node_d  = goal_q;
          cnt_d   = CNT_W'(1);
          state_d = ST_WALK_RD;
        end else begin
          cur_idx_d = deq_idx;
          cur_row_d = deq_row;
          cur_col_d = deq_col;
          dir_d     = DIR_LEFT;
          pend_d    = 1'b0;
          state_d   = ST_NB;
        end
      end
      ST_NB: begin
        vis_re     = nb_ok;
        vis_raddr  = nb_idx;
        pend_d     = nb_ok;
        prev_idx_d = nb_idx;
        prev_row_d = nb_row;
        prev_col_d = nb_col;
        case (dir_q)
          DIR_LEFT:  dir_d = DIR_UP;
          DIR_UP:    dir_d = DIR_DOWN;
          DIR_DOWN:  dir_d = DIR_RIGHT;
          default:   state_d = ST_NB_END;
        endcase
      end
      ST_NB_END: begin
        pend_d  = 1'b0;
        state_d = ST_DEQ;
      end
      ST_WALK_RD: begin
        vis_re    = 1'b1;
        vis_raddr = node_q;
        state_d   = ST_WALK_CHK;
      end
      ST_WALK_CHK: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d    = 1'b1;
          out_d.cell_res = CELL_W'(node_q);
          out_d.last     = walk_last;
          if (walk_last) begin
            if (epoch_q == EPOCH_MAX) begin
              clr_d   = '0;
              state_d = ST_CLEAR;
            end else begin
              epoch_d = epoch_q + EPOCH_W'(1);
              state_d = ST_IDLE;
            end
          end else begin
            node_d  = par;
            cnt_d   = cnt_q + CNT_W'(1);
            state_d = ST_WALK_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      dir_q       <= DIR_LEFT;
      head_q      <= '0;
      tail_q      <= '0;
      pend_q      <= 1'b0;
      cnt_q       <= '0;
      epoch_q     <= EPOCH_ONE;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dir_q       <= dir_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
      epoch_q     <= epoch_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q    <= start_d;
    goal_q     <= goal_d;
    rem_q      <= rem_d;
    row_q      <= row_d;
    cur_row_q  <= cur_row_d;
    cur_col_q  <= cur_col_d;
    cur_idx_q  <= cur_idx_d;
    prev_idx_q <= prev_idx_d;
    prev_row_q <= prev_row_d;
    prev_col_q <= prev_col_d;
    node_q     <= node_d;
    out_q      <= out_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for grid_bfs_path_finder: directed corner cases, then random requests.
// A scoreboard class runs its own breadth-first search per request and checks every result beat.
// Depends on gbfs_pkg and the grid_bfs_path_finder RTL.
module tb_top
  import gbfs_pkg::*;
();

  localparam int COLS           = COLS_DEF;
  localparam int ROWS           = ROWS_DEF;
  localparam int NCELLS         = COLS * ROWS;
  localparam int MAX_BEATS      = COLS + ROWS - 2;
  localparam int IDLE_MAX       = 19;
  localparam int RANDOM_ITEMS   = 228;
  localparam int SETTLE_CYCLES  = 2000;
  localparam int WATCHDOG_LIMIT = 20000;

  class path_scoreboard;
    bit             seen[NCELLS];
    bit [CELL_W-1:0] parent_of[NCELLS];
    bit [CELL_W-1:0] frontier[NCELLS];
    int unsigned    q_head;
    int unsigned    q_tail;
    gbfs_res_t      expected_q[$];
    int             errors;

    function void discover(int unsigned idx, int unsigned from);
      if (idx >= NCELLS || seen[idx]) return;
      seen[idx] = 1'b1;
      parent_of[idx] = from[CELL_W-1:0];
      if (q_tail < NCELLS) begin
        frontier[q_tail] = idx[CELL_W-1:0];
        q_tail++;
      end
    endfunction

    function void note_request(gbfs_req_t req);
      int unsigned src;
      int unsigned dst;
      int unsigned cur;
      int unsigned node;
      int unsigned nxt;
      int unsigned path[$];
      gbfs_res_t   beat;
      src = req.start_cell;
      dst = req.goal_cell;
      if (src >= NCELLS || dst >= NCELLS) return;
      foreach (seen[i]) seen[i] = 1'b0;
      frontier[0] = src[CELL_W-1:0];
      q_head = 0;
      q_tail = 1;
      while (q_head < q_tail) begin
        cur = frontier[q_head];
        if (cur == dst) break;
        seen[cur] = 1'b1;
        q_head++;
        if (cur % COLS > 0) discover(cur - 1, cur);
        if (cur / COLS > 0) discover(cur - COLS, cur);
        if (cur / COLS < ROWS - 1) discover(cur + COLS, cur);
        if (cur % COLS < COLS - 1) discover(cur + 1, cur);
      end
      path.push_back(dst);
      node = dst;
      if (dst != src) begin
        while (path.size() < MAX_BEATS) begin
          nxt = parent_of[node];
          if (nxt >= NCELLS || nxt == src) break;
          node = nxt;
          path.push_back(node);
        end
      end
      foreach (path[i]) begin
        beat.cell_res = path[i][CELL_W-1:0];
        beat.last = (i == path.size() - 1);
        expected_q.push_back(beat);
      end
    endfunction

    function void check_result(gbfs_res_t got);
      gbfs_res_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat, cell_res %0d last %0b",
                 $time, got.cell_res, got.last);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.cell_res !== want.cell_res) begin
        $display("%0t: cell_res mismatch, expected %0d actual %0d",
                 $time, want.cell_res, got.cell_res);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last mismatch, expected %0b actual %0b", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  gbfs_req_t in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  gbfs_res_t out_data_o;

  path_scoreboard sb = new();
  bit             src_calm = 1'b0;
  int             idle_cycles = 0;

  grid_bfs_path_finder #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  task automatic send_request(input int src, input int dst);
    int gap;
    gap = src_calm ? 0 : $urandom_range(0, IDLE_MAX);
    if ($urandom_range(0, 24) == 0) src_calm = !src_calm;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i.start_cell <= src[CELL_W-1:0];
    in_data_i.goal_cell <= dst[CELL_W-1:0];
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
    if (rst_ni && in_valid_i && in_ready_o) sb.note_request(in_data_i);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin : result_sink
    int stall;
    bit sink_calm;
    sink_calm = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = sink_calm ? 0 : $urandom_range(0, IDLE_MAX);
      if ($urandom_range(0, 24) == 0) sink_calm = !sink_calm;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : stimulus
    int src;
    int dst;
    int pick;
    int n_sent;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(0, 0);
    send_request(0, 191);
    send_request(191, 0);
    send_request(15, 176);
    send_request(176, 15);
    send_request(191, 191);
    send_request(17, 16);
    send_request(17, 1);
    send_request(17, 33);
    send_request(17, 18);
    send_request(100, 37);
    send_request(37, 100);
    send_request(192, 5);
    send_request(5, 192);
    send_request(255, 0);
    send_request(0, 255);
    send_request(255, 255);
    send_request(128, 127);
    send_request(127, 128);
    send_request(85, 170);
    send_request(170, 85);
    send_request(8, 8);

    n_sent = 0;
    while (n_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 15);
      src = $urandom_range(0, NCELLS - 1);
      dst = $urandom_range(0, NCELLS - 1);
      case (pick)
        0: begin
          src = $urandom_range(NCELLS, 255);
          dst = $urandom_range(0, 255);
        end
        1: begin
          dst = $urandom_range(NCELLS, 255);
        end
        2: begin
          dst = src;
        end
        3: begin
          dst = (src % COLS < COLS - 1) ? src + 1 : src - 1;
        end
        4: begin
          dst = (src / COLS < ROWS - 1) ? src + COLS : src - COLS;
        end
        default: begin
        end
      endcase
      send_request(src, dst);
      n_sent++;
    end
    in_valid_i <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
